// ----- sv/stepper_ramp_profile_generator_top_assert.svh -----
// Assertion macros for the stepper ramp profile generator.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef STEPPER_RAMP_PROFILE_GENERATOR_TOP_ASSERT_SVH
`define STEPPER_RAMP_PROFILE_GENERATOR_TOP_ASSERT_SVH

// Antecedent in this cycle requires the consequent in the same cycle.
`define SRPG_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle requires the consequent in the next cycle.
`define SRPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/srpg_pkg.sv -----
// Shared types and constants of the stepper ramp profile generator.
// Used by the control, output and top-level modules; no dependencies.
`timescale 1ns / 1ps

package srpg_pkg;

  // Default sizing of the ramp table and the step counter.
  localparam int unsigned RAMP_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned STEP_COUNT_BITS_DEF  = 24;

  // Fixed field widths.
  localparam int unsigned CMD_BITS       = 2;
  localparam int unsigned TABLE_IDX_BITS = 10;
  localparam int unsigned PERIOD_BITS    = 16;
  localparam int unsigned MOVE_BITS      = 24;
  localparam int unsigned LIMIT_BITS     = 10;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 24;

  // Command codes.
  localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_BITS-1:0] RAMP_LIMIT_RST = 10'd512;
  localparam logic [MOVE_BITS-1:0]  THRESHOLD_RST  = 24'd1536;

  // Ramp phase codes.
  localparam logic [1:0] PH_ACC    = 2'd0;
  localparam logic [1:0] PH_CRUISE = 2'd1;
  localparam logic [1:0] PH_DEC    = 2'd2;
  localparam logic [1:0] PH_IDLE   = 2'd3;

  // Division by three through a reciprocal, exact for 16-bit operands.
  localparam int unsigned RAMP_DIVISOR = 3;
  localparam logic [31:0] DIV3_RECIP   = 32'h0000_AAAB;
  localparam int unsigned DIV3_SHIFT   = 17;

  // Per-item result flags travelling from control to the output stage.
  typedef struct packed {
    logic       step_pulse;
    logic       period_valid;
    logic       direction;
    logic       running;
    logic       move_done;
    logic [1:0] phase;
  } srpg_res_t;

endpackage

// ----- sv/srpg_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module srpg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/srpg_ctrl.sv -----
// Command decode and move state of the stepper ramp profile generator.
// Depends on srpg_pkg; drives the write and read ports of the ramp table RAM.
`timescale 1ns / 1ps

module srpg_ctrl
  import srpg_pkg::*;
#(
  parameter int unsigned RAMP_TABLE_DEPTH = RAMP_TABLE_DEPTH_DEF,
  parameter int unsigned STEP_COUNT_BITS  = STEP_COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [CMD_BITS-1:0]                 cmd_i,
  input  logic [TABLE_IDX_BITS-1:0]           table_index_i,
  input  logic [PERIOD_BITS-1:0]              table_value_i,
  input  logic [MOVE_BITS-1:0]                move_steps_i,
  input  logic                                move_reverse_i,
  input  logic                                force_full_ramp_i,
  input  logic                                cfg_valid_i,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data_i,
  output logic                                ram_we_o,
  output logic [$clog2(RAMP_TABLE_DEPTH)-1:0] ram_waddr_o,
  output logic [PERIOD_BITS-1:0]              ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(RAMP_TABLE_DEPTH)-1:0] ram_raddr_o,
  output srpg_res_t                           res_o
);

  localparam int unsigned AW = $clog2(RAMP_TABLE_DEPTH);
  localparam int unsigned SW = STEP_COUNT_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(RAMP_TABLE_DEPTH - 1);
  localparam logic [31:0] DIV_SAT_AT = 32'(RAMP_DIVISOR * (RAMP_TABLE_DEPTH - 1));

  // Configuration registers.
  logic [LIMIT_BITS-1:0] ramp_limit_q;
  logic [MOVE_BITS-1:0]  threshold_q;

  // Move state.
  logic [1:0]    phase_q, phase_d;
  logic [SW-1:0] steps_done_q, steps_done_d;
  logic [SW-1:0] target_q, target_d;
  logic [AW-1:0] ramp_len_q, ramp_len_d;
  logic          timer_on_q, timer_on_d;
  logic          dir_q, dir_d;

  // Start helpers.
  logic [31:0]   limit_ext, steps_ext, tidx_ext, quot_prod, quot_ext;
  logic [AW-1:0] limit_len, div_len, start_len;

  // Tick helpers.
  logic [SW-1:0] steps_inc, steps_left, dec_diff;
  logic [31:0]   dec_diff_ext;
  logic [AW-1:0] dec_idx;

  logic pulse, pvalid, done;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_limit_q <= RAMP_LIMIT_RST;
      threshold_q  <= THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RAMP_LIMIT: ramp_limit_q <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_THRESHOLD:  threshold_q  <= cfg_data_i[MOVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Ramp length candidates for a start, both saturated below the table depth.
  assign limit_ext = 32'(ramp_limit_q);
  assign limit_len = (limit_ext > 32'(RAMP_TABLE_DEPTH - 1)) ? LAST_IDX : limit_ext[AW-1:0];
  assign steps_ext = 32'(move_steps_i);
  assign quot_prod = 32'(move_steps_i[15:0]) * DIV3_RECIP;
  assign quot_ext  = quot_prod >> DIV3_SHIFT;
  assign div_len   = (steps_ext >= DIV_SAT_AT) ? LAST_IDX : quot_ext[AW-1:0];
  assign start_len = (force_full_ramp_i || (move_steps_i >= threshold_q)) ? limit_len : div_len;

  // Tick arithmetic on the step count.
  assign steps_inc    = steps_done_q + SW'(1);
  assign steps_left   = (target_q > steps_inc) ? (target_q - steps_inc) : '0;
  assign dec_diff     = target_q - steps_inc;
  assign dec_diff_ext = 32'(dec_diff);
  assign dec_idx      = (dec_diff_ext >= 32'(RAMP_TABLE_DEPTH - 1)) ? LAST_IDX
                                                                     : dec_diff_ext[AW-1:0];

  // Table load address; loads beyond the table are dropped.
  assign tidx_ext    = 32'(table_index_i);
  assign ram_waddr_o = tidx_ext[AW-1:0];
  assign ram_wdata_o = table_value_i;

  // Next state and result for the beat at the input.
  always_comb begin
    phase_d      = phase_q;
    steps_done_d = steps_done_q;
    target_d     = target_q;
    ramp_len_d   = ramp_len_q;
    timer_on_d   = timer_on_q;
    dir_d        = dir_q;
    pulse        = 1'b0;
    pvalid       = 1'b0;
    done         = 1'b0;
    ram_we_o     = 1'b0;
    ram_raddr_o  = steps_inc[AW-1:0];

    if (cmd_i == CMD_LOAD) begin
      ram_we_o = accept_i && (tidx_ext < 32'(RAMP_TABLE_DEPTH));
    end else if (cmd_i == CMD_START) begin
      if (move_steps_i == '0) begin
        steps_done_d = '0;
        done         = 1'b1;
      end else begin
        ramp_len_d   = start_len;
        target_d     = steps_ext[SW-1:0];
        steps_done_d = '0;
        phase_d      = PH_ACC;
        dir_d        = move_reverse_i;
        timer_on_d   = 1'b1;
      end
    end else if (cmd_i == CMD_TICK && timer_on_q) begin
      pulse        = 1'b1;
      steps_done_d = steps_inc;
      unique case (phase_q)
        PH_ACC: begin
          if (32'(steps_inc) < 32'(ramp_len_q)) begin
            pvalid = 1'b1;
          end else begin
            phase_d = PH_CRUISE;
          end
        end
        PH_CRUISE: begin
          if (32'(steps_left) <= 32'(ramp_len_q)) begin
            phase_d = PH_DEC;
          end
        end
        PH_DEC: begin
          if (steps_inc >= target_q) begin
            phase_d    = PH_IDLE;
            timer_on_d = 1'b0;
            done       = 1'b1;
          end else begin
            pvalid      = 1'b1;
            ram_raddr_o = dec_idx;
          end
        end
        default: begin
          timer_on_d = 1'b0;
          done       = 1'b1;
        end
      endcase
    end
  end

  assign ram_re_o = accept_i && pvalid;

  assign res_o.step_pulse   = pulse;
  assign res_o.period_valid = pvalid;
  assign res_o.direction    = dir_d;
  assign res_o.running      = timer_on_d;
  assign res_o.move_done    = done;
  assign res_o.phase        = phase_d;

  // State registers advance on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      steps_done_q <= '0;
      target_q     <= '0;
      ramp_len_q   <= '0;
      timer_on_q   <= 1'b0;
      dir_q        <= 1'b0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      steps_done_q <= steps_done_d;
      target_q     <= target_d;
      ramp_len_q   <= ramp_len_d;
      timer_on_q   <= timer_on_d;
      dir_q        <= dir_d;
    end
  end

endmodule

// ----- sv/srpg_out.sv -----
// Result stage and output register of the stepper ramp profile generator.
// Depends on srpg_pkg; merges the registered table read with the result flags.
`timescale 1ns / 1ps

module srpg_out
  import srpg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  srpg_res_t              res_i,
  input  logic [PERIOD_BITS-1:0] ram_rdata_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   step_pulse_o,
  output logic [PERIOD_BITS-1:0] period_value_o,
  output logic                   period_valid_o,
  output logic                   direction_out_o,
  output logic                   running_o,
  output logic                   move_done_o,
  output logic [1:0]             phase_o
);

  logic                   s1_valid_q, s1_valid_d;
  srpg_res_t              s1_res_q;
  logic                   s1_adv;
  logic [PERIOD_BITS-1:0] s1_period;
  logic                   out_valid_q, out_valid_d;
  srpg_res_t              out_res_q;
  logic [PERIOD_BITS-1:0] out_period_q;

  // The result stage moves on whenever the output register is free or emptying.
  assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign ready_o   = !s1_valid_q || s1_adv;
  assign s1_period = s1_res_q.period_valid ? ram_rdata_i : '0;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_res_q <= res_i;
    end
    if (s1_adv) begin
      out_res_q    <= s1_res_q;
      out_period_q <= s1_period;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_pulse_o    = out_res_q.step_pulse;
  assign period_value_o  = out_period_q;
  assign period_valid_o  = out_res_q.period_valid;
  assign direction_out_o = out_res_q.direction;
  assign running_o       = out_res_q.running;
  assign move_done_o     = out_res_q.move_done;
  assign phase_o         = out_res_q.phase;

endmodule

// ----- sv/stepper_ramp_profile_generator_top.sv -----
// Top level of the stepper ramp profile generator.
// Depends on srpg_pkg, srpg_ram, srpg_ctrl, srpg_out and the assertion header.
`timescale 1ns / 1ps

// The block takes one beat per clock cycle while in_stall_o is low (loads, starts
// and ticks alike); each result passes through the registered read of the ramp
// table RAM and then the output register. The move state updates in the cycle a
// beat is accepted, so a tick may follow a start or a load directly, and a load
// is visible to the very next tick. The ramp table comes up undefined; every
// entry a move will read must be loaded first. There is no clearing pass after
// reset. RAMP_TABLE_DEPTH ranges from 16 to 4096, STEP_COUNT_BITS from 16 to
// 32. The configuration port is always ready and must only be written while no
// move results are outstanding.
module stepper_ramp_profile_generator_top
  import srpg_pkg::*;
#(
  parameter int unsigned RAMP_TABLE_DEPTH = RAMP_TABLE_DEPTH_DEF,
  parameter int unsigned STEP_COUNT_BITS  = STEP_COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CMD_BITS-1:0]       cmd_i,
  input  logic [TABLE_IDX_BITS-1:0] table_index_i,
  input  logic [PERIOD_BITS-1:0]    table_value_i,
  input  logic [MOVE_BITS-1:0]      move_steps_i,
  input  logic                      move_reverse_i,
  input  logic                      force_full_ramp_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      step_pulse_o,
  output logic [PERIOD_BITS-1:0]    period_value_o,
  output logic                      period_valid_o,
  output logic                      direction_out_o,
  output logic                      running_o,
  output logic                      move_done_o,
  output logic [1:0]                phase_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

`include "stepper_ramp_profile_generator_top_assert.svh"

  localparam int unsigned AddrBits = $clog2(RAMP_TABLE_DEPTH);

  logic                   accept;
  logic                   stage_ready;
  srpg_res_t              res;
  logic                   ram_we, ram_re;
  logic [AddrBits-1:0]    ram_waddr, ram_raddr;
  logic [PERIOD_BITS-1:0] ram_wdata, ram_rdata;

  // Input handshake.
  assign in_stall_o  = !stage_ready;
  assign accept      = in_valid_i && stage_ready;
  assign cfg_ready_o = 1'b1;

  srpg_ctrl #(
    .RAMP_TABLE_DEPTH(RAMP_TABLE_DEPTH),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .cmd_i            (cmd_i),
    .table_index_i    (table_index_i),
    .table_value_i    (table_value_i),
    .move_steps_i     (move_steps_i),
    .move_reverse_i   (move_reverse_i),
    .force_full_ramp_i(force_full_ramp_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_re_o         (ram_re),
    .ram_raddr_o      (ram_raddr),
    .res_o            (res)
  );

  // Ramp table of timer periods.
  srpg_ram #(
    .WIDTH(PERIOD_BITS),
    .DEPTH(RAMP_TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  srpg_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .res_i          (res),
    .ram_rdata_i    (ram_rdata),
    .ready_o        (stage_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .step_pulse_o   (step_pulse_o),
    .period_value_o (period_value_o),
    .period_valid_o (period_valid_o),
    .direction_out_o(direction_out_o),
    .running_o      (running_o),
    .move_done_o    (move_done_o),
    .phase_o        (phase_o)
  );

  // A new period only comes with a pulse of a move that keeps running.
  `SRPG_ASSERT_IMPLIES(a_period_in_move, out_valid_o && period_valid_o, step_pulse_o && running_o, "period without running pulse")

  // A move that ends on a tick stops the timer and rests in idle.
  `SRPG_ASSERT_IMPLIES(a_done_stops, out_valid_o && move_done_o && step_pulse_o, !running_o && (phase_o == PH_IDLE), "finished move still running")

  // With the output register empty the input side must never stall.
  `SRPG_ASSERT_IMPLIES(a_no_stall_when_empty, !out_valid_o, !in_stall_o, "input stalled with empty output")

  // A stalled result beat stays on the port.
  `SRPG_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i, out_valid_o, "stalled result dropped")

endmodule
